FILE: hdl/assert_macros.svh
// Assertion helpers used by the cache datapath.
// Each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EQC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition forces a consequence in the same cycle.
`define EQC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/eqc_pkg.sv
package eqc_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int MAX_BYTES_DEF  = 512;
    localparam int NAME_WORDS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int WORD_W   = 64;
    localparam int KEY_W    = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_NAME     = 2'd0,
        CMD_GET      = 2'd1,
        CMD_PUT_HDR  = 2'd2,
        CMD_PUT_WORD = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        RSP_OK    = 2'd0,
        RSP_MISS  = 2'd1,
        RSP_SMALL = 2'd2,
        RSP_LONG  = 2'd3
    } rsp_code_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [WORD_W-1:0]  name_word;
        logic [KEY_W-1:0]   query_type;
        logic [KEY_W-1:0]   query_class;
        logic [TIME_W-1:0]  time_value;
        logic [COUNT_W-1:0] byte_count;
        logic [WORD_W-1:0]  payload_word;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    stored_length;
        logic [WORD_W-1:0]   response_word;
        logic                last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_META,
        S_NAME,
        S_DECIDE,
        S_COPY,
        S_COMMIT,
        S_ONE,
        S_GET_RD,
        S_GET_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NAME,
        OP_PUT_WORD,
        OP_TAKE,
        OP_ADV,
        OP_STEP,
        OP_HIT,
        OP_COPY_START,
        OP_COPY_STEP,
        OP_COMMIT,
        OP_EMIT_ONE,
        OP_GET_START,
        OP_GET_EMIT
    } op_t;

    typedef struct packed {
        logic meta_match;
        logic word_match;
        logic last_entry;
        logic last_word;
        logic hit;
        logic is_put;
        logic too_long;
        logic single;
        logic last_get_word;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/eqc_stream_if.sv
interface eqc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/eqc_ctrl.sv
module eqc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [eqc_pkg::CMD_W-1:0]    req_cmd,
    output logic                         req_ready,
    input  eqc_pkg::dp_status_t          stat,
    output eqc_pkg::op_t                 op
);

    eqc_pkg::state_t state_reg;
    eqc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eqc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eqc_pkg::S_IDLE:
            begin
                if (req_valid && (req_cmd == eqc_pkg::CMD_GET || req_cmd == eqc_pkg::CMD_PUT_HDR))
                begin
                    state_next = eqc_pkg::S_META;
                end
            end
            eqc_pkg::S_META:
            begin
                if (stat.is_put && stat.too_long)
                begin
                    state_next = eqc_pkg::S_ONE;
                end
                else if (stat.meta_match && stat.word_match)
                begin
                    state_next = stat.last_word ? eqc_pkg::S_DECIDE : eqc_pkg::S_NAME;
                end
                else if (stat.last_entry)
                begin
                    state_next = eqc_pkg::S_DECIDE;
                end
            end
            eqc_pkg::S_NAME:
            begin
                if (stat.word_match)
                begin
                    if (stat.last_word)
                    begin
                        state_next = eqc_pkg::S_DECIDE;
                    end
                end
                else
                begin
                    state_next = stat.last_entry ? eqc_pkg::S_DECIDE : eqc_pkg::S_META;
                end
            end
            eqc_pkg::S_DECIDE:
            begin
                if (stat.is_put)
                begin
                    state_next = stat.hit ? eqc_pkg::S_ONE : eqc_pkg::S_COPY;
                end
                else
                begin
                    state_next = stat.single ? eqc_pkg::S_ONE : eqc_pkg::S_GET_RD;
                end
            end
            eqc_pkg::S_COPY:
            begin
                if (stat.last_word)
                begin
                    state_next = eqc_pkg::S_COMMIT;
                end
            end
            eqc_pkg::S_COMMIT:
            begin
                state_next = eqc_pkg::S_ONE;
            end
            eqc_pkg::S_ONE:
            begin
                if (stat.out_free)
                begin
                    state_next = eqc_pkg::S_IDLE;
                end
            end
            eqc_pkg::S_GET_RD:
            begin
                state_next = eqc_pkg::S_GET_OUT;
            end
            eqc_pkg::S_GET_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_get_word ? eqc_pkg::S_IDLE : eqc_pkg::S_GET_RD;
                end
            end
            default:
            begin
                state_next = eqc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op        = eqc_pkg::OP_NONE;
        req_ready = 1'b0;
        case (state_reg)
            eqc_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (req_cmd)
                        eqc_pkg::CMD_NAME:     op = eqc_pkg::OP_NAME;
                        eqc_pkg::CMD_PUT_WORD: op = eqc_pkg::OP_PUT_WORD;
                        default:               op = eqc_pkg::OP_TAKE;
                    endcase
                end
            end
            eqc_pkg::S_META:
            begin
                if (!(stat.is_put && stat.too_long))
                begin
                    if (stat.meta_match && stat.word_match)
                    begin
                        op = stat.last_word ? eqc_pkg::OP_HIT : eqc_pkg::OP_STEP;
                    end
                    else if (!stat.last_entry)
                    begin
                        op = eqc_pkg::OP_ADV;
                    end
                end
            end
            eqc_pkg::S_NAME:
            begin
                if (stat.word_match)
                begin
                    op = stat.last_word ? eqc_pkg::OP_HIT : eqc_pkg::OP_STEP;
                end
                else if (!stat.last_entry)
                begin
                    op = eqc_pkg::OP_ADV;
                end
            end
            eqc_pkg::S_DECIDE:
            begin
                if (stat.is_put)
                begin
                    op = stat.hit ? eqc_pkg::OP_COMMIT : eqc_pkg::OP_COPY_START;
                end
                else if (!stat.single)
                begin
                    op = eqc_pkg::OP_GET_START;
                end
            end
            eqc_pkg::S_COPY:
            begin
                op = eqc_pkg::OP_COPY_STEP;
            end
            eqc_pkg::S_COMMIT:
            begin
                op = eqc_pkg::OP_COMMIT;
            end
            eqc_pkg::S_ONE:
            begin
                if (stat.out_free)
                begin
                    op = eqc_pkg::OP_EMIT_ONE;
                end
            end
            eqc_pkg::S_GET_OUT:
            begin
                if (stat.out_free)
                begin
                    op = eqc_pkg::OP_GET_EMIT;
                end
            end
            default:
            begin
                op = eqc_pkg::OP_NONE;
            end
        endcase
    end

endmodule

FILE: hdl/eqc_datapath.sv
`include "assert_macros.svh"

module eqc_datapath #(
    parameter int ENTRIES            = eqc_pkg::ENTRIES_DEF,
    parameter int MAX_RESPONSE_BYTES = eqc_pkg::MAX_BYTES_DEF,
    parameter int NAME_WORDS         = eqc_pkg::NAME_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eqc_pkg::req_t        req_data,
    input  eqc_pkg::op_t         op,
    output eqc_pkg::dp_status_t  stat,
    eqc_stream_if.source         rsp
);

    localparam int PW    = (MAX_RESPONSE_BYTES + 7) / 8;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int W_W   = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
    localparam int CNT_W = $clog2(NAME_WORDS + 1);
    localparam int PWI_W = (PW > 1) ? $clog2(PW) : 1;
    localparam int PWL_W = $clog2(PW + 1);
    localparam int NA_W  = (ENTRIES * NAME_WORDS > 1) ? $clog2(ENTRIES * NAME_WORDS) : 1;
    localparam int PA_W  = (ENTRIES * PW > 1) ? $clog2(ENTRIES * PW) : 1;
    localparam int LEN_W = eqc_pkg::LEN_W;
    localparam int WORD_W = eqc_pkg::WORD_W;

    typedef struct packed {
        logic [eqc_pkg::KEY_W-1:0]  qtype;
        logic [eqc_pkg::KEY_W-1:0]  qclass;
        logic [eqc_pkg::TIME_W-1:0] expiry;
        logic [LEN_W-1:0]           length;
    } meta_t;

    // Zero every byte from the first zero byte on; carry the end mark across words.
    function automatic logic [WORD_W:0] norm_word(input logic [WORD_W-1:0] v,
                                                  input logic ended_in);
        logic              e;
        logic [WORD_W-1:0] r;
        e = ended_in;
        r = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (!e)
            begin
                if (v[8*b +: 8] == 8'h00)
                begin
                    e = 1'b1;
                end
                else
                begin
                    r[8*b +: 8] = v[8*b +: 8];
                end
            end
        end
        return {e, r};
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            m[8*b +: 8] = (n > LEN_W'(b)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Storage
    logic [WORD_W-1:0] key_mem  [NAME_WORDS];
    logic [WORD_W-1:0] name_mem [ENTRIES * NAME_WORDS];
    meta_t             meta_mem [ENTRIES];
    logic [WORD_W-1:0] pay_mem  [ENTRIES * PW];

    eqc_pkg::req_t      hdr_reg;
    logic               is_put_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [W_W-1:0]     w_reg;
    logic [W_W-1:0]     w_next;
    logic [IDX_W-1:0]   tgt_reg;
    logic [IDX_W-1:0]   rp_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   key_cnt_reg;
    logic               ended_reg;
    logic [IDX_W-1:0]   put_tgt_reg;
    logic [LEN_W-1:0]   put_len_reg;
    logic [PWI_W-1:0]   put_idx_reg;
    logic [PWL_W-1:0]   put_left_reg;
    logic [PWI_W-1:0]   pw_reg;
    logic               out_valid_reg;
    eqc_pkg::rsp_t      out_reg;

    logic [WORD_W-1:0]  key_rd_reg;
    logic               key_ok_reg;
    logic [WORD_W-1:0]  name_rd_reg;
    meta_t              meta_rd_reg;
    logic [WORD_W-1:0]  pay_rd_reg;

    logic [WORD_W-1:0]  key_word;
    logic [WORD_W:0]    norm;
    logic               last_entry;
    logic               last_word;
    logic               expired;
    logic               too_small;
    logic               too_long;
    logic               single;
    logic [LEN_W:0]     len_sum;
    logic [PWL_W-1:0]   get_words;
    logic               last_get_word;
    logic               out_free;
    logic               emit;
    logic [NA_W-1:0]    name_rd_addr;
    logic [NA_W-1:0]    name_wr_addr;
    logic [PA_W-1:0]    pay_rd_addr;
    logic [PA_W-1:0]    pay_wr_addr;
    logic [eqc_pkg::COUNT_W:0] put_sum;

    assign key_word   = key_ok_reg ? key_rd_reg : '0;
    assign norm       = norm_word(req_data.name_word, ended_reg);
    assign last_entry = (idx_reg == IDX_W'(ENTRIES - 1));
    assign last_word  = (w_reg == W_W'(NAME_WORDS - 1));
    assign expired    = (meta_rd_reg.expiry <= hdr_reg.time_value);
    assign too_small  = (hdr_reg.byte_count < eqc_pkg::COUNT_W'(meta_rd_reg.length));
    assign too_long   = (hdr_reg.byte_count > eqc_pkg::COUNT_W'(MAX_RESPONSE_BYTES));
    assign single     = !hit_reg || expired || too_small || (meta_rd_reg.length == '0);
    assign len_sum    = {1'b0, meta_rd_reg.length} + (LEN_W + 1)'(7);
    assign get_words  = PWL_W'(len_sum >> 3);
    assign last_get_word = ((PWL_W'(pw_reg) + PWL_W'(1)) == get_words);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign emit       = (op == eqc_pkg::OP_EMIT_ONE) || (op == eqc_pkg::OP_GET_EMIT);
    assign put_sum    = {1'b0, hdr_reg.byte_count} + (eqc_pkg::COUNT_W + 1)'(7);

    assign stat.meta_match    = valid_reg[idx_reg]
                                && (meta_rd_reg.qtype == hdr_reg.query_type)
                                && (meta_rd_reg.qclass == hdr_reg.query_class);
    assign stat.word_match    = (name_rd_reg == key_word);
    assign stat.last_entry    = last_entry;
    assign stat.last_word     = last_word;
    assign stat.hit           = hit_reg;
    assign stat.is_put        = is_put_reg;
    assign stat.too_long      = too_long;
    assign stat.single        = single;
    assign stat.last_get_word = last_get_word;
    assign stat.out_free      = out_free;

    // Scan counters; memories read at the next values so data lines up with the registers.
    always_comb
    begin
        idx_next = idx_reg;
        w_next   = w_reg;
        case (op)
            eqc_pkg::OP_TAKE:
            begin
                idx_next = '0;
                w_next   = '0;
            end
            eqc_pkg::OP_ADV:
            begin
                idx_next = last_entry ? '0 : idx_reg + IDX_W'(1);
                w_next   = '0;
            end
            eqc_pkg::OP_STEP, eqc_pkg::OP_COPY_STEP:
            begin
                w_next = last_word ? '0 : w_reg + W_W'(1);
            end
            eqc_pkg::OP_COPY_START:
            begin
                w_next = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    assign name_rd_addr = NA_W'(idx_next) * NA_W'(NAME_WORDS) + NA_W'(w_next);
    assign name_wr_addr = NA_W'(tgt_reg) * NA_W'(NAME_WORDS) + NA_W'(w_reg);
    assign pay_rd_addr  = PA_W'(tgt_reg) * PA_W'(PW) + PA_W'(pw_reg);
    assign pay_wr_addr  = PA_W'(put_tgt_reg) * PA_W'(PW) + PA_W'(put_idx_reg);

    always_ff @(posedge clk)
    begin
        if (op == eqc_pkg::OP_NAME && key_cnt_reg < CNT_W'(NAME_WORDS))
        begin
            key_mem[key_cnt_reg[W_W-1:0]] <= norm[WORD_W-1:0];
        end
        key_rd_reg <= key_mem[w_next];
        key_ok_reg <= (CNT_W'(w_next) < key_cnt_reg);

        if (op == eqc_pkg::OP_COPY_STEP)
        begin
            name_mem[name_wr_addr] <= key_word;
        end
        name_rd_reg <= name_mem[name_rd_addr];

        if (op == eqc_pkg::OP_COMMIT)
        begin
            meta_mem[tgt_reg] <= '{qtype:  hdr_reg.query_type,
                                   qclass: hdr_reg.query_class,
                                   expiry: hdr_reg.time_value,
                                   length: LEN_W'(hdr_reg.byte_count)};
        end
        meta_rd_reg <= meta_mem[idx_next];

        if (op == eqc_pkg::OP_PUT_WORD && put_left_reg != '0)
        begin
            pay_mem[pay_wr_addr] <= req_data.payload_word
                                    & byte_mask(put_len_reg - LEN_W'({put_idx_reg, 3'b000}));
        end
        pay_rd_reg <= pay_mem[pay_rd_addr];
    end

    // Header and output payload
    always_ff @(posedge clk)
    begin
        if (op == eqc_pkg::OP_TAKE)
        begin
            hdr_reg <= req_data;
        end
        if (op == eqc_pkg::OP_EMIT_ONE)
        begin
            out_reg.response_word <= '0;
            out_reg.last          <= 1'b1;
            if (is_put_reg)
            begin
                out_reg.status        <= too_long ? eqc_pkg::RSP_LONG : eqc_pkg::RSP_OK;
                out_reg.stored_length <= too_long ? '0 : LEN_W'(hdr_reg.byte_count);
            end
            else if (!hit_reg || expired)
            begin
                out_reg.status        <= eqc_pkg::RSP_MISS;
                out_reg.stored_length <= '0;
            end
            else if (too_small)
            begin
                out_reg.status        <= eqc_pkg::RSP_SMALL;
                out_reg.stored_length <= meta_rd_reg.length;
            end
            else
            begin
                out_reg.status        <= eqc_pkg::RSP_OK;
                out_reg.stored_length <= '0;
            end
        end
        else if (op == eqc_pkg::OP_GET_EMIT)
        begin
            out_reg.status        <= eqc_pkg::RSP_OK;
            out_reg.stored_length <= meta_rd_reg.length;
            out_reg.response_word <= pay_rd_reg
                                     & byte_mask(meta_rd_reg.length
                                                 - LEN_W'({pw_reg, 3'b000}));
            out_reg.last          <= last_get_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_put_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
            w_reg         <= '0;
            tgt_reg       <= '0;
            rp_reg        <= '0;
            valid_reg     <= '0;
            key_cnt_reg   <= '0;
            ended_reg     <= 1'b0;
            put_tgt_reg   <= '0;
            put_len_reg   <= '0;
            put_idx_reg   <= '0;
            put_left_reg  <= '0;
            pw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            w_reg   <= w_next;

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (op)
                eqc_pkg::OP_NAME:
                begin
                    if (key_cnt_reg < CNT_W'(NAME_WORDS))
                    begin
                        key_cnt_reg <= key_cnt_reg + CNT_W'(1);
                        ended_reg   <= norm[WORD_W];
                    end
                end
                eqc_pkg::OP_PUT_WORD:
                begin
                    if (put_left_reg != '0)
                    begin
                        put_idx_reg  <= put_idx_reg + PWI_W'(1);
                        put_left_reg <= put_left_reg - PWL_W'(1);
                    end
                end
                eqc_pkg::OP_TAKE:
                begin
                    is_put_reg <= (req_data.command == eqc_pkg::CMD_PUT_HDR);
                    hit_reg    <= 1'b0;
                    // A new put header closes any open put.
                    if (req_data.command == eqc_pkg::CMD_PUT_HDR)
                    begin
                        put_left_reg <= '0;
                    end
                end
                eqc_pkg::OP_HIT:
                begin
                    hit_reg <= 1'b1;
                    tgt_reg <= idx_reg;
                end
                eqc_pkg::OP_COPY_START:
                begin
                    tgt_reg <= rp_reg;
                end
                eqc_pkg::OP_COMMIT:
                begin
                    put_tgt_reg  <= tgt_reg;
                    put_len_reg  <= LEN_W'(hdr_reg.byte_count);
                    put_idx_reg  <= '0;
                    put_left_reg <= PWL_W'(put_sum >> 3);
                    if (!hit_reg)
                    begin
                        valid_reg[tgt_reg] <= 1'b1;
                        rp_reg <= (rp_reg == IDX_W'(ENTRIES - 1)) ? '0 : rp_reg + IDX_W'(1);
                    end
                end
                eqc_pkg::OP_EMIT_ONE:
                begin
                    key_cnt_reg <= '0;
                    ended_reg   <= 1'b0;
                end
                eqc_pkg::OP_GET_START:
                begin
                    pw_reg <= '0;
                end
                eqc_pkg::OP_GET_EMIT:
                begin
                    pw_reg <= pw_reg + PWI_W'(1);
                    if (last_get_word)
                    begin
                        key_cnt_reg <= '0;
                        ended_reg   <= 1'b0;
                    end
                end
                default:
                begin
                    pw_reg <= pw_reg;
                end
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    `EQC_ASSERT_IMPL(a_emit_room, emit, out_free, "result loaded over a waiting result")
    `EQC_ASSERT(a_commit_valid, (op == eqc_pkg::OP_COMMIT) |=> valid_reg[$past(tgt_reg)], "committed slot not valid")
    `EQC_ASSERT_IMPL(a_adv_range, op == eqc_pkg::OP_ADV, !last_entry, "scan advanced past last entry")

endmodule

FILE: hdl/expiring_query_cache_fifo.sv
// Channel | Dir | Word
// req     | in  | command, name_word, query_type, query_class, time_value, byte_count,
//         |     | payload_word
// rsp     | out | status, stored_length, response_word, last
//
// Name word and put payload word: taken while idle, no result.
// Get / put header: scan compares one name word at a time per entry; an entry that
// is invalid or mismatches on type/class or a name word is passed over at once.
// A put that misses copies the key into the entry's name words before the commit.
// A get hit reads each response word from payload memory, then outputs it.
// Reset clears valid bits at once; no clearing pass. rsp.ready low holds the result
// register; the next request is taken while a result waits.
module expiring_query_cache_fifo #(
    parameter int ENTRIES            = eqc_pkg::ENTRIES_DEF,
    parameter int MAX_RESPONSE_BYTES = eqc_pkg::MAX_BYTES_DEF,
    parameter int NAME_WORDS         = eqc_pkg::NAME_WORDS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    eqc_stream_if.sink   req,
    eqc_stream_if.source rsp
);

    eqc_pkg::dp_status_t stat;
    eqc_pkg::op_t        op;
    logic                ctrl_ready;

    assign req.ready = ctrl_ready;

    eqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.data.command),
        .req_ready (ctrl_ready),
        .stat      (stat),
        .op        (op)
    );

    eqc_datapath #(
        .ENTRIES            (ENTRIES),
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES),
        .NAME_WORDS         (NAME_WORDS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .op       (op),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
